/* rtl/multichannel_symmetric_fir_noise_shaper_assert.svh */
// Assertion macros for the noise shaper checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTICHANNEL_SYMMETRIC_FIR_NOISE_SHAPER_ASSERT_SVH
`define MULTICHANNEL_SYMMETRIC_FIR_NOISE_SHAPER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MSFN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("noise shaper check failed (same-cycle implication)");

// Next-cycle implication, disabled while in reset
`define MSFN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("noise shaper check failed (next-cycle implication)");

`endif

/* rtl/msfn_pkg.sv */
// Shared types and constants for the multichannel symmetric FIR noise shaper.
// No dependencies; every other file in rtl but the assertion macro header imports this package.
package msfn_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int MAX_TAPS_DEF    = 256;
    localparam int CHANNELS_DEF    = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEFF_BITS_DEF  = 18;

    // Fixed field widths
    localparam int CHAN_W      = 4;
    localparam int CIDX_W      = 8;
    localparam int OUT_BITS    = 24;
    localparam int TAP_REG_W   = 9;
    localparam int CHAN_REG_W  = 5;
    localparam int SHIFT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TAP_COUNT     = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1,
        CFG_OUT_SHIFT     = 2'd2
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [TAP_REG_W-1:0]  TAP_COUNT_RST     = 9'd1;
    localparam logic [CHAN_REG_W-1:0] CHANNEL_COUNT_RST = 5'd1;
    localparam logic [SHIFT_W-1:0]    OUT_SHIFT_RST     = 5'd17;

    // Item commands
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    // Output saturation limits
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = 24'sh800000;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_wr;   // write one zero word of the clearing sweep
        logic coef_wr;    // store the coefficient of the current word
        logic take;       // latch a push word, fetch its ring position
        logic mod_step;   // one restoring step of the position reduce
        logic set_pos;    // store sample, advance position, set up the walk
        logic mac_issue;  // issue one tap pair read
        logic out_load;   // shift, saturate and present the result
    } msfn_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic push_ok;
        logic load_ok;
        logic mod_last;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } msfn_status_t;

endpackage

/* rtl/msfn_item_if.sv */
// Input channel of the noise shaper: valid/ready plus push/load payload.
// Depends on msfn_pkg for field widths.
interface msfn_item_if
    import msfn_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [CHAN_W-1:0]             channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CIDX_W-1:0]             coeff_index;
    logic signed [COEFF_BITS-1:0]  coeff_value;

    modport source (
        output valid, cmd, channel, sample, coeff_index, coeff_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, channel, sample, coeff_index, coeff_value,
        output ready
    );

endinterface

/* rtl/msfn_result_if.sv */
// Output channel of the noise shaper: valid/ready plus filtered result.
// Depends on msfn_pkg for field widths.
interface msfn_result_if
    import msfn_pkg::*;
();

    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          out_channel;
    logic signed [OUT_BITS-1:0] filtered_value;
    logic                       saturated;

    modport source (
        output valid, out_channel, filtered_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_channel, filtered_value, saturated,
        output ready
    );

endinterface

/* rtl/msfn_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// Depends on msfn_pkg for default sizes.
module msfn_ram
    import msfn_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF,
    parameter int DEPTH = MAX_TAPS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

/* rtl/msfn_ctrl.sv */
// Controller of the noise shaper: sequences clearing, loads and the tap walk.
// Depends on msfn_pkg for the command and status structs.
module msfn_ctrl
    import msfn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_cmd,
    output logic         item_ready,
    output msfn_cmd_t    cmd,
    input  msfn_status_t status
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_MOD    = 7'b0000100,
        ST_POS    = 7'b0001000,
        ST_MAC    = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_cmd == CMD_LOAD)
                    begin
                        cmd.coef_wr = status.load_ok;
                    end
                    else if (status.push_ok)
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                cmd.set_pos = 1'b1;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (status.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/msfn_datapath.sv */
// Datapath of the noise shaper: configuration, delay lines, coefficient store,
// position reduce, shared multiply-accumulate and output stage.
// Depends on msfn_pkg and msfn_ram.
module msfn_datapath
    import msfn_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  msfn_cmd_t                     cmd,
    output msfn_status_t                  status,
    input  logic [CHAN_W-1:0]             item_channel,
    input  logic signed [SAMPLE_BITS-1:0] item_sample,
    input  logic [CIDX_W-1:0]             item_coeff_index,
    input  logic signed [COEFF_BITS-1:0]  item_coeff_value,
    input  logic                          result_ready,
    output logic                          result_valid,
    output logic [CHAN_W-1:0]             result_out_channel,
    output logic signed [OUT_BITS-1:0]    result_filtered_value,
    output logic                          result_saturated,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int RING_MAX = 2 * MAX_TAPS - 1;
    localparam int PW       = $clog2(RING_MAX);
    localparam int RW       = $clog2(2 * MAX_TAPS);
    localparam int XW       = RW + 1;
    localparam int TCW      = $clog2(MAX_TAPS + 1);
    localparam int KW       = $clog2(MAX_TAPS);
    localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNW      = $clog2(CHANNELS + 1);
    localparam int SDEPTH   = CHANNELS * RING_MAX;
    localparam int SAW      = $clog2(SDEPTH);
    localparam int SW       = $clog2(PW);
    localparam int PAIR_W   = SAMPLE_BITS + 1;
    localparam int PROD_W   = COEFF_BITS + PAIR_W;
    localparam int ACC_RAW  = PROD_W + KW + 1;
    localparam int AW       = (ACC_RAW > OUT_BITS) ? ACC_RAW : OUT_BITS + 1;

    // Configuration
    logic [TAP_REG_W-1:0]  tap_count_reg;
    logic [CHAN_REG_W-1:0] channel_count_reg;
    logic [SHIFT_W-1:0]    out_shift_reg;
    logic [TCW-1:0]        taps_eff;
    logic [CNW-1:0]        chans_eff;

    // Per-push state
    logic [CHAN_W-1:0]             chan_reg;
    logic [CW-1:0]                 ch_idx;
    logic [CW-1:0]                 in_ch_idx;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [SAW-1:0]                base_reg;
    logic [TCW-1:0]                taps_reg;
    logic [RW-1:0]                 len_reg;
    logic [PW-1:0]                 rem_reg;
    logic [SW-1:0]                 step_reg;
    logic [PW-1:0]                 np_reg [CHANNELS];
    logic [PW+RW-1:0]              trial;
    logic [XW-1:0]                 pos_wide;
    logic [PW-1:0]                 pos;
    logic [XW-1:0]                 centre_sum;
    logic [PW-1:0]                 centre;

    // Tap walk and multiply-accumulate pipeline
    logic [PW-1:0]                 up_reg;
    logic [PW-1:0]                 dn_reg;
    logic [KW-1:0]                 k_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          v3_reg;
    logic                          first1_reg;
    logic signed [SAMPLE_BITS-1:0] up_data;
    logic signed [SAMPLE_BITS-1:0] dn_data;
    logic signed [COEFF_BITS-1:0]  coef_data;
    logic signed [PAIR_W-1:0]      dn_term;
    logic signed [PAIR_W-1:0]      pair_reg;
    logic signed [COEFF_BITS-1:0]  coef_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [AW-1:0]          acc_reg;

    // Sample store write port and clearing sweep
    logic [SAW-1:0]                clear_reg;
    logic                          s_we;
    logic [SAW-1:0]                s_waddr;
    logic [SAMPLE_BITS-1:0]        s_wdata;

    // Output stage
    logic signed [AW-1:0]          shifted;
    logic [AW-OUT_BITS:0]          top_bits;
    logic                          fits;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg     <= TAP_COUNT_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
            out_shift_reg     <= OUT_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_COUNT:     tap_count_reg     <= cfg_data[TAP_REG_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_REG_W-1:0];
                CFG_OUT_SHIFT:     out_shift_reg     <= cfg_data[SHIFT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp tap and channel counts to the supported range
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = TCW'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            taps_eff = TCW'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TCW'(tap_count_reg);
        end

        if (channel_count_reg == '0)
        begin
            chans_eff = CNW'(1);
        end
        else if (32'(channel_count_reg) > CHANNELS)
        begin
            chans_eff = CNW'(CHANNELS);
        end
        else
        begin
            chans_eff = CNW'(channel_count_reg);
        end
    end

    assign in_ch_idx = CW'(32'(item_channel));
    assign ch_idx    = CW'(32'(chan_reg));

    // Position reduce, new position and centre of the window
    assign trial      = (PW + RW)'(len_reg) << step_reg;
    assign pos_wide   = XW'(rem_reg) + XW'(1);
    assign pos        = (pos_wide == XW'(len_reg)) ? '0 : pos_wide[PW-1:0];
    assign centre_sum = XW'(pos) + XW'(taps_reg);
    assign centre     = (centre_sum >= XW'(len_reg)) ? PW'(centre_sum - XW'(len_reg))
                                                     : centre_sum[PW-1:0];

    // Latch a push word, then reduce its ring position one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            chan_reg   <= item_channel;
            sample_reg <= item_sample;
            base_reg   <= SAW'(32'(in_ch_idx) * RING_MAX);
            taps_reg   <= taps_eff;
            len_reg    <= RW'({taps_eff, 1'b0} - (TCW + 1)'(1));
            rem_reg    <= np_reg[in_ch_idx];
            step_reg   <= SW'(PW - 1);
        end
        else if (cmd.mod_step)
        begin
            if ((PW + RW)'(rem_reg) >= trial)
            begin
                rem_reg <= rem_reg - trial[PW-1:0];
            end
            step_reg <= step_reg - SW'(1);
        end
    end

    // Newest position of each channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                np_reg[i] <= '0;
            end
        end
        else if (cmd.set_pos)
        begin
            np_reg[ch_idx] <= pos;
        end
    end

    // Walk the tap pairs outward from the centre
    always_ff @(posedge clk)
    begin
        if (cmd.set_pos)
        begin
            up_reg <= centre;
            dn_reg <= centre;
            k_reg  <= '0;
        end
        else if (cmd.mac_issue)
        begin
            up_reg <= (XW'(up_reg) + XW'(1) == XW'(len_reg)) ? '0 : up_reg + PW'(1);
            dn_reg <= (dn_reg == '0) ? PW'(len_reg - RW'(1)) : dn_reg - PW'(1);
            k_reg  <= k_reg + KW'(1);
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Pair sum, product and accumulate; the centre tap counts once
    assign dn_term = first1_reg ? '0 : PAIR_W'(dn_data);

    always_ff @(posedge clk)
    begin
        first1_reg <= (k_reg == '0);
        pair_reg   <= PAIR_W'(up_data) + dn_term;
        coef_reg   <= coef_data;
        prod_reg   <= coef_reg * pair_reg;
        if (cmd.set_pos)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    // Clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clear_reg <= clear_reg + SAW'(1);
        end
    end

    // Sample store write: zero during the sweep, new sample otherwise
    always_comb
    begin
        s_we    = cmd.clear_wr | cmd.set_pos;
        s_waddr = cmd.clear_wr ? clear_reg : base_reg + SAW'(pos);
        s_wdata = cmd.clear_wr ? '0 : sample_reg;
    end

    msfn_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SDEPTH)
    ) u_sample_ram (
        .clk     (clk),
        .we      (s_we),
        .waddr   (s_waddr),
        .wdata   (s_wdata),
        .ra_addr (base_reg + SAW'(up_reg)),
        .ra_data (up_data),
        .rb_addr (base_reg + SAW'(dn_reg)),
        .rb_data (dn_data)
    );

    msfn_ram #(
        .WIDTH (COEFF_BITS),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .we      (cmd.coef_wr),
        .waddr   (KW'(32'(item_coeff_index))),
        .wdata   (item_coeff_value),
        .ra_addr (k_reg),
        .ra_data (coef_data),
        .rb_addr (k_reg),
        .rb_data ()
    );

    // Shift and saturate
    assign shifted  = acc_reg >>> out_shift_reg;
    assign top_bits = shifted[AW-1:OUT_BITS-1];
    assign fits     = (&top_bits) | ~(|top_bits);

    // Output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_out_channel    <= chan_reg;
            result_filtered_value <= fits ? shifted[OUT_BITS-1:0]
                                          : (shifted[AW-1] ? OUT_MIN : OUT_MAX);
            result_saturated      <= ~fits;
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.clear_last = (clear_reg == SAW'(SDEPTH - 1));
        status.push_ok    = (32'(item_channel) < 32'(chans_eff));
        status.load_ok    = (32'(item_coeff_index) < MAX_TAPS);
        status.mod_last   = (step_reg == '0);
        status.last_tap   = (XW'(k_reg) + XW'(1) == XW'(taps_reg));
        status.pipe_busy  = v1_reg | v2_reg | v3_reg;
        status.out_free   = ~result_valid | result_ready;
    end

endmodule

/* rtl/multichannel_symmetric_fir_noise_shaper.sv */
// Multichannel symmetric FIR noise shaper. A push word stores one white sample in
// its channel's delay line and yields one result word; a load word writes one
// kernel coefficient and keeps input ready. A push first reduces the stored ring
// position one bit per cycle, stores the sample, lets the single shared
// multiply-accumulate walk one symmetric tap pair per cycle (tap_count taken as
// 1..MAX_TAPS), drains the four-stage pipeline and loads the output register.
// Input stays blocked throughout, and the next word is taken in the cycle after
// the output register is loaded at the earliest. If the previous result still
// waits in the output register, the new result holds until it leaves and input
// stays blocked meanwhile. A push to a channel outside channel_count, or a load
// beyond the kernel, is taken and dropped. After reset every word of the sample
// store is swept to zero; no word is accepted until it ends, while configuration
// writes are taken throughout.
module multichannel_symmetric_fir_noise_shaper
    import msfn_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    msfn_item_if.sink              item,
    msfn_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    msfn_cmd_t    cmd;
    msfn_status_t status;

    // Sequencer
    msfn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .item_ready (item.ready),
        .cmd        (cmd),
        .status     (status)
    );

    // Storage and arithmetic
    msfn_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .item_channel          (item.channel),
        .item_sample           (item.sample),
        .item_coeff_index      (item.coeff_index),
        .item_coeff_value      (item.coeff_value),
        .result_ready          (result.ready),
        .result_valid          (result.valid),
        .result_out_channel    (result.out_channel),
        .result_filtered_value (result.filtered_value),
        .result_saturated      (result.saturated),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

endmodule

/* rtl/msfn_checker.sv */
// Port-level checks for the noise shaper, attached to the top level by bind.
// Depends on msfn_pkg and the assertion macro header.
`include "multichannel_symmetric_fir_noise_shaper_assert.svh"

module msfn_checker
    import msfn_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       item_cmd,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic signed [OUT_BITS-1:0] result_filtered_value,
    input logic                       result_saturated
);

    // Clearing sweep holds off input right after reset
    `MSFN_ASSERT_IMP(a_ready_low_after_reset, !$past(rst_n), !item_ready)

    // A load never blocks the following word
    `MSFN_ASSERT_NXT(a_load_keeps_ready, item_valid && item_ready && item_cmd == CMD_LOAD, item_ready)

    // A result appears only after a busy cycle
    `MSFN_ASSERT_IMP(a_result_after_busy, $rose(result_valid), !$past(item_ready))

    // A clipped result sits at a limit
    `MSFN_ASSERT_IMP(a_sat_at_limit, result_valid && result_saturated, result_filtered_value == OUT_MAX || result_filtered_value == OUT_MIN)

    // A stalled result holds its value
    `MSFN_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_filtered_value))

endmodule

bind multichannel_symmetric_fir_noise_shaper msfn_checker u_msfn_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .item_valid            (item.valid),
    .item_ready            (item.ready),
    .item_cmd              (item.cmd),
    .result_valid          (result.valid),
    .result_ready          (result.ready),
    .result_filtered_value (result.filtered_value),
    .result_saturated      (result.saturated)
);

/* sim/msfn_shaping_check.sv */
`timescale 1ns / 100ps
// Checker for the noise shaper: keeps its own kernel, delay lines and registers,
// predicts every filtered word and compares it with the word the block sends.
// Depends on msfn_pkg and the msfn_item_if / msfn_result_if interfaces.
module msfn_shaping_check
    import msfn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    msfn_item_if                   item,
    msfn_result_if                 result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     results_due
);

    localparam int TAPS_MAX = MAX_TAPS_DEF;
    localparam int RING_LEN = 2 * TAPS_MAX - 1;
    localparam int N_CHAN   = CHANNELS_DEF;

    typedef struct packed {
        logic [CHAN_W-1:0]          chan;
        logic signed [OUT_BITS-1:0] value;
        logic                       clipped;
    } shaped_word_t;

    // Mirrored registers and storage
    logic [TAP_REG_W-1:0]              tap_reg;
    logic [CHAN_REG_W-1:0]             chan_reg;
    logic [SHIFT_W-1:0]                shift_reg;
    logic signed [COEFF_BITS_DEF-1:0]  kernel [TAPS_MAX];
    logic signed [SAMPLE_BITS_DEF-1:0] delay_line [N_CHAN][RING_LEN];
    int unsigned                       head_pos [N_CHAN];
    int unsigned                       chan_limit;

    shaped_word_t shaped_queue [$];
    shaped_word_t want;

    // Out-of-range channel counts clamp to 1 and to the channel total
    always_comb
    begin
        if (chan_reg == 0)
            chan_limit = 1;
        else if (chan_reg > N_CHAN)
            chan_limit = N_CHAN;
        else
            chan_limit = chan_reg;
    end

    // Store one sample in its delay line and compute the shaped output word
    function automatic shaped_word_t shape_sample(input logic [CHAN_W-1:0] ch,
                                                  input logic signed [SAMPLE_BITS_DEF-1:0] s);
        int unsigned  taps;
        int unsigned  span;
        int unsigned  pos;
        int unsigned  mid;
        int unsigned  up;
        int unsigned  dn;
        longint       acc;
        longint       pair;
        longint       scaled;
        shaped_word_t w;

        if (tap_reg == 0)
            taps = 1;
        else if (tap_reg > TAPS_MAX)
            taps = TAPS_MAX;
        else
            taps = tap_reg;
        span = 2 * taps - 1;

        // advance the ring; a stale position from a wider kernel wraps first
        pos = (head_pos[ch] % span + 1) % span;
        head_pos[ch] = pos;
        delay_line[ch][pos] = s;

        // centre tap, then symmetric pairs around it
        mid = (pos + span - (taps - 1)) % span;
        acc = longint'(kernel[0]) * longint'(delay_line[ch][mid]);
        for (int unsigned k = 1; k < taps; k++)
        begin
            up   = (mid + k) % span;
            dn   = (mid + span - k) % span;
            pair = longint'(delay_line[ch][up]) + longint'(delay_line[ch][dn]);
            acc += longint'(kernel[k]) * pair;
        end

        // floor shift, then clip to the output width
        scaled    = acc >>> shift_reg;
        w.clipped = 1'b0;
        if (scaled > longint'(OUT_MAX))
        begin
            scaled    = longint'(OUT_MAX);
            w.clipped = 1'b1;
        end
        else if (scaled < longint'(OUT_MIN))
        begin
            scaled    = longint'(OUT_MIN);
            w.clipped = 1'b1;
        end
        w.value = scaled[OUT_BITS-1:0];
        w.chan  = ch;
        return w;
    endfunction

    // Track register writes and accepted words, compare every result word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg   = TAP_COUNT_RST;
            chan_reg  = CHANNEL_COUNT_RST;
            shift_reg = OUT_SHIFT_RST;
            foreach (kernel[i])
                kernel[i] = '0;
            foreach (delay_line[c, p])
                delay_line[c][p] = '0;
            foreach (head_pos[c])
                head_pos[c] = 0;
            shaped_queue.delete();
            mismatches  = 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TAP_COUNT:     tap_reg   = cfg_data[TAP_REG_W-1:0];
                    CFG_CHANNEL_COUNT: chan_reg  = cfg_data[CHAN_REG_W-1:0];
                    CFG_OUT_SHIFT:     shift_reg = cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            // a push to an unused channel leaves no trace
            if (item.valid && item.ready)
            begin
                if (item.cmd == CMD_LOAD)
                    kernel[item.coeff_index] = item.coeff_value;
                else if (item.channel < chan_limit)
                    shaped_queue.insert(shaped_queue.size(),
                                        shape_sample(item.channel, item.sample));
            end

            if (result.valid && result.ready)
            begin
                if (shaped_queue.size() == 0)
                begin
                    $error("result word on channel %0d with nothing expected",
                           result.out_channel);
                    mismatches++;
                end
                else
                begin
                    want = shaped_queue.pop_front();
                    if (result.out_channel !== want.chan)
                    begin
                        $error("out_channel: expected %0d, actual %0d",
                               want.chan, result.out_channel);
                        mismatches++;
                    end
                    if (result.filtered_value !== want.value)
                    begin
                        $error("filtered_value: expected %0d, actual %0d",
                               want.value, result.filtered_value);
                        mismatches++;
                    end
                    if (result.saturated !== want.clipped)
                    begin
                        $error("saturated: expected %0d, actual %0d",
                               want.clipped, result.saturated);
                        mismatches++;
                    end
                end
            end
            results_due <= shaped_queue.size();
        end
    end

endmodule

/* sim/tb_multichannel_symmetric_fir_noise_shaper.sv */
`timescale 1ns / 100ps
// Top of the noise shaper testbench: clock, reset, kernel loads, pushes and
// register settings under idle, stall and back-pressure phases, and the verdict.
// Depends on msfn_pkg, both channel interfaces, the block and msfn_shaping_check.
module tb_multichannel_symmetric_fir_noise_shaper;
    import msfn_pkg::*;

    // Push latency at the full kernel, plus margin
    localparam int SETTLE_CYCLES = MAX_TAPS_DEF + 40;
    localparam int HOLD_CYCLES   = 3000;

    localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_HI = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS_DEF-1:0] SAMPLE_LO = 16'sh8000;
    localparam logic signed [COEFF_BITS_DEF-1:0]  COEFF_HI  = 18'sh1FFFF;
    localparam logic signed [COEFF_BITS_DEF-1:0]  COEFF_LO  = 18'sh20000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int hold_seq       = 0;
    int active_chans   = 1;
    int pushes_sent    = 0;
    int loads_sent     = 0;
    int settings_used  = 0;
    int fail_count;
    int results_due;

    msfn_item_if   item_ch ();
    msfn_result_if result_ch ();

    multichannel_symmetric_fir_noise_shaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msfn_shaping_check shaping_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (fail_count),
        .results_due (results_due)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin : result_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_HI;
            1:       return SAMPLE_LO;
            default: return SAMPLE_BITS_DEF'($urandom());
        endcase
    endfunction

    function automatic logic signed [COEFF_BITS_DEF-1:0] pick_coeff();
        case ($urandom_range(7))
            0:       return COEFF_HI;
            1:       return COEFF_LO;
            default: return COEFF_BITS_DEF'($urandom());
        endcase
    endfunction

    // Offer one word after a random idle gap and hold it until taken
    task automatic send_word(input cmd_t c, input logic [CHAN_W-1:0] ch,
                             input logic signed [SAMPLE_BITS_DEF-1:0] smp,
                             input logic [CIDX_W-1:0] idx,
                             input logic signed [COEFF_BITS_DEF-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.cmd         <= c;
        item_ch.channel     <= ch;
        item_ch.sample      <= smp;
        item_ch.coeff_index <= idx;
        item_ch.coeff_value <= val;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (c == CMD_LOAD)
            loads_sent++;
        else
            pushes_sent++;
    endtask

    // Unused fields carry random bits
    task automatic push(input logic [CHAN_W-1:0] ch,
                        input logic signed [SAMPLE_BITS_DEF-1:0] smp);
        send_word(CMD_PUSH, ch, smp, CIDX_W'($urandom()), COEFF_BITS_DEF'($urandom()));
    endtask

    task automatic load_coeff(input logic [CIDX_W-1:0] idx,
                              input logic signed [COEFF_BITS_DEF-1:0] val);
        send_word(CMD_LOAD, CHAN_W'($urandom()), SAMPLE_BITS_DEF'($urandom()), idx, val);
    endtask

    // Drop valid, wait for every expected word, then let the block go idle
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers while the block is idle
    task automatic apply_settings(input logic [TAP_REG_W-1:0] taps,
                                  input logic [CHAN_REG_W-1:0] chans,
                                  input logic [SHIFT_W-1:0] shift);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAP_COUNT;
        cfg_data  <= CFG_DATA_W'(taps);
        @(posedge clk);
        cfg_index <= CFG_CHANNEL_COUNT;
        cfg_data  <= CFG_DATA_W'(chans);
        @(posedge clk);
        cfg_index <= CFG_OUT_SHIFT;
        cfg_data  <= CFG_DATA_W'(shift);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (chans == 0)
            active_chans = 1;
        else if (chans > CHANNELS_DEF)
            active_chans = CHANNELS_DEF;
        else
            active_chans = chans;
        settings_used++;
    endtask

    // Mostly pushes to live channels, some loads, a few pushes to dead channels
    task automatic run_random(input int count);
        int done_items;
        int ch;
        done_items = 0;
        while (done_items < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                load_coeff(CIDX_W'($urandom_range(MAX_TAPS_DEF - 1)), pick_coeff());
                done_items++;
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    ch = $urandom_range(CHANNELS_DEF - 1);
                else
                    ch = $urandom_range(active_chans - 1);
                if (ch < active_chans)
                    done_items++;
                push(CHAN_W'(ch), pick_sample());
            end
        end
    endtask

    task automatic run_phase(input logic [TAP_REG_W-1:0] taps,
                             input logic [CHAN_REG_W-1:0] chans,
                             input logic [SHIFT_W-1:0] shift,
                             input int idle, input int stall, input int count);
        apply_settings(taps, chans, shift);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        run_random(count);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_TAP_COUNT;
        cfg_data            <= '0;
        item_ch.valid       <= 1'b0;
        item_ch.cmd         <= CMD_PUSH;
        item_ch.channel     <= '0;
        item_ch.sample      <= '0;
        item_ch.coeff_index <= '0;
        item_ch.coeff_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole kernel so no tap is ever read unwritten
        for (int i = 0; i < MAX_TAPS_DEF; i++)
            load_coeff(CIDX_W'(i), pick_coeff());

        // Extremes with no shift: both saturation directions, edge channels
        apply_settings(3, 16, 0);
        load_coeff(0, COEFF_HI);
        load_coeff(1, COEFF_LO);
        load_coeff(2, -1);
        push(0, SAMPLE_HI);
        push(0, SAMPLE_LO);
        push(15, SAMPLE_HI);
        push(15, SAMPLE_LO);
        push(7, '0);
        push(0, SAMPLE_HI);

        // Zero tap and channel counts act as one; channel 1 is then unused
        apply_settings(0, 0, 31);
        push(0, SAMPLE_LO);
        push(1, SAMPLE_HI);
        push(0, SAMPLE_HI);

        // Counts above range clamp to the full kernel and all channels
        apply_settings(511, 31, 17);
        push(3, SAMPLE_LO);
        push(15, SAMPLE_HI);

        apply_settings(256, 16, 5);
        load_coeff(255, COEFF_LO);
        push(8, pick_sample());
        push(8, SAMPLE_HI);

        // Random phases; sender pauses for a full drain partway through the first
        run_phase(4, 16, 14, 0, 0, 15);
        wait_drained();
        run_random(10);
        run_phase(9, 5, 16, 81, 0, 20);
        run_phase(1, 1, 0, 0, 81, 20);
        run_phase(17, 16, 20, 6, 6, 20);

        // Long result hold-off while the sender keeps offering
        apply_settings(2, 16, 10);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = HOLD_CYCLES;
        hold_seq++;
        run_random(20);

        run_phase(256, 3, 22, 6, 6, 4);
        run_phase(33, 8, 18, 0, 0, 12);
        run_phase(5, 16, 31, 6, 6, 12);

        wait_drained();
        $display("Run covered %0d pushes and %0d kernel loads over %0d register settings,",
                 pushes_sent, loads_sent, settings_used);
        $display("with idle, stall and long hold-off phases on both sides.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
